@@ hdl/tcca_pkg.sv @@
// Shared types, constants and bit-manipulation helpers for the truth-table
// cofactor analyzer. No dependencies.

package tcca_pkg;

  localparam int MAX_VARS    = 8;                // largest supported function
  localparam int LOW_VARS    = 5;                // variables resolved inside one word
  localparam int WORD_W      = 32;
  localparam int ADDR_W      = MAX_VARS - LOW_VARS;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int VAR_W       = $clog2(MAX_VARS);
  localparam int NV_W        = 4;                // width of the num_vars register
  localparam int CNT_W       = 8;                // cofactor minterm count
  localparam int POP_W       = $clog2(WORD_W) + 1;

  // Constant-cofactor codes
  localparam logic [1:0] CONST_NONE = 2'd0;
  localparam logic [1:0] CONST_ZERO = 2'd1;
  localparam logic [1:0] CONST_ONE  = 2'd2;

  localparam logic [NV_W-1:0] NV_RESET = NV_W'(MAX_VARS);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } tcca_state_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic              rd_use;     // read pair contributes to the counts
    logic              acc_clr;
    logic              out_load;
    logic [VAR_W-1:0]  var_idx;
    logic [NV_W-1:0]   n_eff;
  } tcca_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic out_free;
  } tcca_stat_t;

  // Minterms with the variable at zero, for the in-word variables
  function automatic logic [WORD_W-1:0] neg_mask(input logic [VAR_W-1:0] v);
    logic [WORD_W-1:0] m;
    case (v)
      VAR_W'(0): m = 32'h5555_5555;
      VAR_W'(1): m = 32'h3333_3333;
      VAR_W'(2): m = 32'h0F0F_0F0F;
      VAR_W'(3): m = 32'h00FF_00FF;
      VAR_W'(4): m = 32'h0000_FFFF;
      default:   m = '0;
    endcase
    return m;
  endfunction

  // Bits of the single word that hold minterms for small functions
  function automatic logic [WORD_W-1:0] used_mask(input logic [NV_W-1:0] n);
    logic [WORD_W-1:0] m;
    case (n)
      NV_W'(1): m = 32'h0000_0003;
      NV_W'(2): m = 32'h0000_000F;
      NV_W'(3): m = 32'h0000_00FF;
      NV_W'(4): m = 32'h0000_FFFF;
      default:  m = '1;
    endcase
    return m;
  endfunction

  // w >> (1 << v) for the in-word variables
  function automatic logic [WORD_W-1:0] shift_down(input logic [WORD_W-1:0] w,
                                                   input logic [VAR_W-1:0]  v);
    logic [WORD_W-1:0] r;
    case (v)
      VAR_W'(0): r = w >> 1;
      VAR_W'(1): r = w >> 2;
      VAR_W'(2): r = w >> 4;
      VAR_W'(3): r = w >> 8;
      VAR_W'(4): r = w >> 16;
      default:   r = '0;
    endcase
    return r;
  endfunction

  // Population count, adder tree
  function automatic logic [POP_W-1:0] ones32(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] v;
    v = (w & 32'h5555_5555) + ((w >> 1) & 32'h5555_5555);
    v = (v & 32'h3333_3333) + ((v >> 2) & 32'h3333_3333);
    v = (v & 32'h0F0F_0F0F) + ((v >> 4) & 32'h0F0F_0F0F);
    v = (v & 32'h00FF_00FF) + ((v >> 8) & 32'h00FF_00FF);
    v = (v & 32'h0000_FFFF) + (v >> 16);
    return v[POP_W-1:0];
  endfunction

endpackage

@@ hdl/tcca_ctrl.sv @@
// Controller for the cofactor analyzer: load/scan/drain/emit state machine, the
// num_vars register and the word, variable and scan counters. Uses tcca_pkg.

module tcca_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tcca_pkg::NV_W-1:0]     cfg_data,
  input  tcca_pkg::tcca_stat_t          stat,
  output tcca_pkg::tcca_cmd_t           cmd
);

  tcca_pkg::tcca_state_t              state, state_next;
  logic [tcca_pkg::NV_W-1:0]          num_vars;
  logic [tcca_pkg::ADDR_W-1:0]        word_cnt, word_cnt_next;
  logic [tcca_pkg::ADDR_W-1:0]        scan_k, scan_k_next;
  logic [tcca_pkg::VAR_W-1:0]         var_idx, var_idx_next;

  logic [tcca_pkg::NV_W-1:0]          n_eff;
  logic [tcca_pkg::ADDR_W-1:0]        last_word;
  logic [tcca_pkg::ADDR_W-1:0]        hi_bit;
  logic                               var_low;
  logic                               var_last;

  assign cfg_ready = 1'b1;

  // Clamp the variable count to 1..MAX_VARS
  always_comb begin
    if (num_vars == '0) begin
      n_eff = tcca_pkg::NV_W'(1);
    end else if (num_vars > tcca_pkg::NV_W'(tcca_pkg::MAX_VARS)) begin
      n_eff = tcca_pkg::NV_W'(tcca_pkg::MAX_VARS);
    end else begin
      n_eff = num_vars;
    end
  end

  always_comb begin
    if (n_eff < tcca_pkg::NV_W'(tcca_pkg::LOW_VARS)) begin
      last_word = '0;
    end else begin
      last_word = tcca_pkg::ADDR_W'((1 << (n_eff - tcca_pkg::NV_W'(tcca_pkg::LOW_VARS))) - 1);
    end
  end

  assign var_low  = var_idx < tcca_pkg::VAR_W'(tcca_pkg::LOW_VARS);
  assign hi_bit   = var_low ? '0
                  : tcca_pkg::ADDR_W'(1) << (var_idx - tcca_pkg::VAR_W'(tcca_pkg::LOW_VARS));
  assign var_last = {1'b0, var_idx} == tcca_pkg::NV_W'(n_eff - tcca_pkg::NV_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tcca_pkg::ST_LOAD;
      num_vars <= tcca_pkg::NV_RESET;
      word_cnt <= '0;
      scan_k   <= '0;
      var_idx  <= '0;
    end else begin
      state    <= state_next;
      scan_k   <= scan_k_next;
      var_idx  <= var_idx_next;
      if (cfg_valid && cfg_ready) begin
        num_vars <= cfg_data;
        word_cnt <= '0;
      end else begin
        word_cnt <= word_cnt_next;
      end
    end
  end

  always_comb begin
    state_next    = state;
    word_cnt_next = word_cnt;
    scan_k_next   = scan_k;
    var_idx_next  = var_idx;
    in_ready      = 1'b0;

    cmd           = '0;
    cmd.wr_addr   = word_cnt;
    cmd.rd_addr_a = scan_k;
    cmd.rd_addr_b = scan_k | hi_bit;
    cmd.var_idx   = var_idx;
    cmd.n_eff     = n_eff;

    case (state)
      tcca_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.wr_en = 1'b1;
          if (word_cnt == last_word) begin
            word_cnt_next = '0;
            var_idx_next  = '0;
            scan_k_next   = '0;
            cmd.acc_clr   = 1'b1;
            state_next    = tcca_pkg::ST_SCAN;
          end else begin
            word_cnt_next = word_cnt + tcca_pkg::ADDR_W'(1);
          end
        end
      end
      tcca_pkg::ST_SCAN: begin
        // high variables pair word k with word k|bit; skip the upper half
        cmd.rd_use = var_low || ((scan_k & hi_bit) == '0);
        if (scan_k == last_word) begin
          state_next = tcca_pkg::ST_DRAIN;
        end else begin
          scan_k_next = scan_k + tcca_pkg::ADDR_W'(1);
        end
      end
      tcca_pkg::ST_DRAIN: begin
        state_next = tcca_pkg::ST_EMIT;
      end
      tcca_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (var_last) begin
            state_next = tcca_pkg::ST_LOAD;
          end else begin
            var_idx_next = var_idx + tcca_pkg::VAR_W'(1);
            scan_k_next  = '0;
            cmd.acc_clr  = 1'b1;
            state_next   = tcca_pkg::ST_SCAN;
          end
        end
      end
      default: begin
        state_next = tcca_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

@@ hdl/tcca_dp.sv @@
// Datapath for the cofactor analyzer: truth-table memory with two registered
// read ports, count/compare accumulators and the result register. Uses tcca_pkg.

module tcca_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  tcca_pkg::tcca_cmd_t             cmd,
  output tcca_pkg::tcca_stat_t            stat,
  input  logic [tcca_pkg::WORD_W-1:0]     truth_word,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tcca_pkg::VAR_W-1:0]      var_index,
  output logic [tcca_pkg::CNT_W-1:0]      count_neg,
  output logic [tcca_pkg::CNT_W-1:0]      count_pos,
  output logic                            cofactors_equal,
  output logic                            cofactors_complement,
  output logic [1:0]                      neg_is_const,
  output logic [1:0]                      pos_is_const,
  output logic                            last_result
);

  logic [tcca_pkg::WORD_W-1:0] table_store [tcca_pkg::STORE_DEPTH];
  logic [tcca_pkg::WORD_W-1:0] rd_a, rd_b;
  logic                        rd_valid;

  logic [tcca_pkg::CNT_W-1:0]  acc_neg, acc_pos;
  logic                        acc_eq, acc_cp;

  logic [tcca_pkg::WORD_W-1:0] nm, cm, diff;
  logic [tcca_pkg::POP_W-1:0]  add_neg, add_pos;
  logic                        mis_eq, mis_cp;
  logic [tcca_pkg::CNT_W-1:0]  cof_size;

  // Memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      table_store[cmd.wr_addr] <= truth_word & tcca_pkg::used_mask(cmd.n_eff);
    end
    rd_a <= table_store[cmd.rd_addr_a];
    rd_b <= table_store[cmd.rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.rd_use;
    end
  end

  always_comb begin
    nm   = tcca_pkg::neg_mask(cmd.var_idx);
    cm   = nm & tcca_pkg::used_mask(cmd.n_eff);
    diff = (rd_a ^ tcca_pkg::shift_down(rd_a, cmd.var_idx)) & cm;
    if (cmd.var_idx < tcca_pkg::VAR_W'(tcca_pkg::LOW_VARS)) begin
      add_neg = tcca_pkg::ones32(rd_a & nm);
      add_pos = tcca_pkg::ones32(rd_a & ~nm);
      mis_eq  = diff != '0;
      mis_cp  = diff != cm;
    end else begin
      add_neg = tcca_pkg::ones32(rd_a);
      add_pos = tcca_pkg::ones32(rd_b);
      mis_eq  = rd_a != rd_b;
      mis_cp  = rd_a != ~rd_b;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_neg <= '0;
      acc_pos <= '0;
      acc_eq  <= 1'b1;
      acc_cp  <= 1'b1;
    end else if (rd_valid) begin
      acc_neg <= acc_neg + tcca_pkg::CNT_W'(add_neg);
      acc_pos <= acc_pos + tcca_pkg::CNT_W'(add_pos);
      acc_eq  <= acc_eq & ~mis_eq;
      acc_cp  <= acc_cp & ~mis_cp;
    end
  end

  assign cof_size = tcca_pkg::CNT_W'(1) << (cmd.n_eff - tcca_pkg::NV_W'(1));

  function automatic logic [1:0] const_code(input logic [tcca_pkg::CNT_W-1:0] c,
                                            input logic [tcca_pkg::CNT_W-1:0] size);
    logic [1:0] r;
    if (c == '0) begin
      r = tcca_pkg::CONST_ZERO;
    end else if (c == size) begin
      r = tcca_pkg::CONST_ONE;
    end else begin
      r = tcca_pkg::CONST_NONE;
    end
    return r;
  endfunction

  assign stat.out_free = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      var_index            <= cmd.var_idx;
      count_neg            <= acc_neg;
      count_pos            <= acc_pos;
      cofactors_equal      <= acc_eq;
      cofactors_complement <= acc_cp;
      neg_is_const         <= const_code(acc_neg, cof_size);
      pos_is_const         <= const_code(acc_pos, cof_size);
      last_result          <= {1'b0, cmd.var_idx} ==
                              tcca_pkg::NV_W'(cmd.n_eff - tcca_pkg::NV_W'(1));
    end
  end

endmodule

@@ hdl/truth_table_cofactor_analyzer_top.sv @@
// Top level of the truth-table cofactor analyzer: ties the controller to the
// datapath. Uses tcca_pkg, tcca_ctrl and tcca_dp.
//
// Loads the truth table of a Boolean function of num_vars variables (1..8,
// 0 acts as 1, above 8 acts as 8), one 32-bit word per request, lowest
// minterms first: 2^(n-5) words for n >= 5, one word otherwise (masked to its
// low 2^n bits). Words are taken at one per cycle. After the last word the
// block produces one result per variable, variable 0 first, with the minterm
// counts of both cofactors, equal/complement flags and constant-cofactor codes;
// last_result marks variable n-1. For each variable the scan walks the stored
// words once through the memory's registered read ports, a drain state lets
// the last read reach the accumulators, and the result is then handed to the
// output register once that register is free. No new word is taken while
// results are being computed; the next table may start loading as soon as the
// last result sits in the output register. Writing num_vars restarts any load
// in progress; write it only when the block is idle.

module truth_table_cofactor_analyzer_top (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tcca_pkg::NV_W-1:0]       cfg_data,
  // truth-table words
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tcca_pkg::WORD_W-1:0]     truth_word,
  // per-variable results
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tcca_pkg::VAR_W-1:0]      var_index,
  output logic [tcca_pkg::CNT_W-1:0]      count_neg,
  output logic [tcca_pkg::CNT_W-1:0]      count_pos,
  output logic                            cofactors_equal,
  output logic                            cofactors_complement,
  output logic [1:0]                      neg_is_const,
  output logic [1:0]                      pos_is_const,
  output logic                            last_result
);

  tcca_pkg::tcca_cmd_t  cmd;
  tcca_pkg::tcca_stat_t stat;

  // sequencing: word count, variable and scan position
  tcca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .cmd       (cmd)
  );

  // table memory, accumulators and result register
  tcca_dp u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .stat                 (stat),
    .truth_word           (truth_word),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .var_index            (var_index),
    .count_neg            (count_neg),
    .count_pos            (count_pos),
    .cofactors_equal      (cofactors_equal),
    .cofactors_complement (cofactors_complement),
    .neg_is_const         (neg_is_const),
    .pos_is_const         (pos_is_const),
    .last_result          (last_result)
  );

endmodule
